/* hw/rtl/tcc_pkg.sv */
`default_nettype none

package tcc_pkg;

  localparam int ROWS_DEFAULT      = 25;
  localparam int COLS_DEFAULT      = 80;
  localparam int TAB_WIDTH_DEFAULT = 8;

  // Width of the row generation tags kept with every cell.
  localparam int GEN_W  = 24;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;

  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int POS_W     = 11;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd10;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_SET   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] char_code;
    logic [5:0]        row_in;
    logic [7:0]        col_in;
  } in_item_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [POS_W-1:0]     cursor_position;
    logic [CELL_W-1:0]    cell_value;
    logic                 set_rejected;
  } out_item_t;

  typedef struct packed {
    logic [GEN_W-1:0]  gen;
    logic [CELL_W-1:0] data;
  } cell_entry_t;

  typedef struct packed {
    logic rejected;
    logic rd_ok;
  } item_flags_t;

endpackage

`default_nettype wire

/* hw/rtl/tcc_cell_store.sv */
`default_nettype none

module tcc_cell_store #(
  parameter int CELLS = tcc_pkg::ROWS_DEFAULT * tcc_pkg::COLS_DEFAULT,
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  tcc_pkg::cell_entry_t wr_entry,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output tcc_pkg::cell_entry_t rd_entry,
  output logic                busy
);
  import tcc_pkg::*;

  cell_entry_t       mem [CELLS];
  logic [ADDR_W-1:0] init_addr;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  cell_entry_t       mem_data;

  // After reset every entry is swept once so that all tags start at zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      init_addr <= '0;
    end else if (busy) begin
      if (init_addr == ADDR_W'(CELLS - 1)) begin
        busy <= 1'b0;
      end
      init_addr <= init_addr + 1'b1;
    end
  end

  always_comb begin
    mem_we   = busy || wr_en;
    mem_addr = busy ? init_addr : wr_addr;
    if (busy) begin
      mem_data.gen  = '0;
      mem_data.data = BLANK_CELL;
    end else begin
      mem_data = wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_data;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tcc_cursor_ctrl.sv */
`default_nettype none

module tcc_cursor_ctrl #(
  parameter int ROWS      = tcc_pkg::ROWS_DEFAULT,
  parameter int COLS      = tcc_pkg::COLS_DEFAULT,
  parameter int TAB_WIDTH = tcc_pkg::TAB_WIDTH_DEFAULT,
  localparam int ROW_W  = $clog2(ROWS),
  localparam int COL_W  = $clog2(COLS),
  localparam int ADDR_W = $clog2(ROWS * COLS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  tcc_pkg::in_item_t           item,
  input  logic                        cfg_wr_en,
  input  logic [tcc_pkg::ATTR_W-1:0]  cfg_wr_data,
  output logic                        wr_en,
  output tcc_pkg::cell_entry_t        wr_entry,
  output logic [ADDR_W-1:0]           cell_addr,
  output logic [ROW_W-1:0]            row,
  output logic [COL_W-1:0]            col,
  output tcc_pkg::item_flags_t        flags,
  output logic [tcc_pkg::GEN_W-1:0]   rd_gen
);
  import tcc_pkg::*;

  localparam int COLX_W = $clog2(COLS + TAB_WIDTH);
  localparam int STEP_W = $clog2(TAB_WIDTH + 1);
  localparam logic [ROW_W:0]      ROWS_X    = (ROW_W + 1)'(ROWS);
  localparam logic [ROW_W-1:0]    LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COLX_W-1:0]   COLS_X    = COLX_W'(COLS);
  localparam logic [ADDR_W-1:0]   COLS_A    = ADDR_W'(COLS);

  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  top_row, top_row_next;
  logic [GEN_W-1:0]  epoch, epoch_next;
  logic [GEN_W-1:0]  row_gen [ROWS];
  logic [GEN_W-1:0]  gen_next [ROWS];
  logic [ATTR_W-1:0] text_attribute;

  logic [STEP_W-1:0] tab_step_tbl [COLS];
  logic [COLX_W-1:0] col_adv;
  logic              new_line;
  logic              wr_req;
  logic              pos_ok;
  logic [ROW_W-1:0]  wr_phys, rd_phys, row_sel;
  logic [COL_W-1:0]  col_sel;
  logic [GEN_W-1:0]  sel_gen;

  // Distance from each column to the next tab stop.
  for (genvar g = 0; g < COLS; g++) begin : g_tab
    assign tab_step_tbl[g] = STEP_W'(TAB_WIDTH - (g % TAB_WIDTH));
  end

  // Screen row to stored row, through the top-row pointer.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                input logic [ROW_W-1:0] r);
    logic [ROW_W:0] s;
    s = {1'b0, top} + {1'b0, r};
    if (s >= ROWS_X) begin
      s = s - ROWS_X;
    end
    return s[ROW_W-1:0];
  endfunction

  always_comb begin
    pos_ok  = ({1'b0, item.row_in} < 7'(ROWS)) && ({1'b0, item.col_in} < 9'(COLS));
    wr_phys = phys_row(top_row, cur_row);
    rd_phys = phys_row(top_row, ROW_W'(item.row_in));
    row_sel = (item.kind == KIND_READ) ? rd_phys : wr_phys;
    col_sel = (item.kind == KIND_READ) ? COL_W'(item.col_in) : cur_col;
    sel_gen = row_gen[row_sel];
    cell_addr = ADDR_W'(row_sel) * COLS_A + ADDR_W'(col_sel);
    rd_gen  = sel_gen;
    wr_entry.gen  = sel_gen;
    wr_entry.data = {text_attribute, item.char_code};
  end

  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    top_row_next = top_row;
    epoch_next   = epoch;
    gen_next     = row_gen;
    flags        = '0;
    col_adv      = '0;
    new_line     = 1'b0;
    wr_req       = 1'b0;

    unique case (item.kind)
      KIND_PUT: begin
        case (item.char_code)
          CH_BS: begin
            col_adv = (cur_col == '0) ? '0 : COLX_W'(cur_col) - COLX_W'(1);
          end
          CH_TAB: col_adv = COLX_W'(cur_col) + COLX_W'(tab_step_tbl[cur_col]);
          CH_CR:  col_adv = '0;
          CH_LF: begin
            col_adv  = '0;
            new_line = 1'b1;
          end
          default: begin
            col_adv = COLX_W'(cur_col) + COLX_W'(1);
            wr_req  = 1'b1;
          end
        endcase

        if (col_adv >= COLS_X) begin
          cur_col_next = '0;
          new_line     = 1'b1;
        end else begin
          cur_col_next = COL_W'(col_adv);
        end

        // Scrolling retires the top row: it gets a fresh generation, so all of
        // its old cells read as blanks from now on.
        if (new_line) begin
          if (cur_row == LAST_ROW) begin
            epoch_next        = epoch + 1'b1;
            gen_next[top_row] = epoch_next;
            top_row_next      = (top_row == LAST_ROW) ? '0 : top_row + 1'b1;
          end else begin
            cur_row_next = cur_row + 1'b1;
          end
        end
      end
      KIND_SET: begin
        if (pos_ok) begin
          cur_row_next = ROW_W'(item.row_in);
          cur_col_next = COL_W'(item.col_in);
        end else begin
          flags.rejected = 1'b1;
        end
      end
      KIND_CLEAR: begin
        epoch_next = epoch + 1'b1;
        for (int i = 0; i < ROWS; i++) begin
          gen_next[i] = epoch_next;
        end
        top_row_next = '0;
        cur_row_next = '0;
        cur_col_next = '0;
      end
      KIND_READ: begin
        if (pos_ok) begin
          flags.rd_ok = 1'b1;
        end else begin
          flags.rejected = 1'b1;
        end
      end
    endcase
  end

  assign wr_en = accept && wr_req;
  assign row   = cur_row_next;
  assign col   = cur_col_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row        <= '0;
      cur_col        <= '0;
      top_row        <= '0;
      epoch          <= '0;
      text_attribute <= ATTR_RESET;
      for (int i = 0; i < ROWS; i++) begin
        row_gen[i] <= '0;
      end
    end else begin
      if (accept) begin
        cur_row <= cur_row_next;
        cur_col <= cur_col_next;
        top_row <= top_row_next;
        epoch   <= epoch_next;
        row_gen <= gen_next;
      end
      if (cfg_wr_en) begin
        text_attribute <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tcc_out_buf.sv */
`default_nettype none

module tcc_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tcc_pkg::out_item_t push_item,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output tcc_pkg::out_item_t out_item
);
  import tcc_pkg::*;

  out_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign space     = (count != 2'd2);
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/text_console_cursor_engine.sv */
// Text console cursor engine.
// Items arrive on item/item_valid/item_ready: put character, set cursor,
// clear screen or read cell. Every accepted item yields exactly one result on
// result/result_valid/result_ready, in order, carrying the cursor after the
// item, its linear position, the cell read (read items only) and a reject
// flag. The attribute byte for written cells is loaded through cfg_wr_en and
// cfg_wr_data; the user must load it only while no item is in flight, which
// the block itself does not enforce. One item is accepted per cycle while
// item_ready is high. An item's state update, cell write and cell read happen
// at its accept edge; its result is registered in a result stage and enters
// the output buffer when the buffer has space. The cell store is a
// single-port-write, one-read memory of ROWS*COLS entries tagged with row
// generations, so scrolling and clearing rewrite no stored cells.
// After reset the store sweeps all ROWS*COLS entries once with item_ready
// low; cursor, top row and attribute start at their reset values. A stalled
// receiver fills a two-item output buffer and one result stage; item_ready
// then drops until results are taken.
`default_nettype none

module text_console_cursor_engine #(
  parameter int ROWS      = tcc_pkg::ROWS_DEFAULT,
  parameter int COLS      = tcc_pkg::COLS_DEFAULT,
  parameter int TAB_WIDTH = tcc_pkg::TAB_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  tcc_pkg::in_item_t          item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output tcc_pkg::out_item_t         result,
  input  logic                       cfg_wr_en,
  input  logic [tcc_pkg::ATTR_W-1:0] cfg_wr_data
);
  import tcc_pkg::*;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = $clog2(ROWS * COLS);
  localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLS);

  logic              accept;
  logic              busy;
  logic              wr_en;
  cell_entry_t       wr_entry;
  cell_entry_t       rd_entry;
  logic [ADDR_W-1:0] cell_addr;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  item_flags_t       flags;
  logic [GEN_W-1:0]  rd_gen;

  logic              s1_valid;
  logic [ROW_W-1:0]  s1_row;
  logic [COL_W-1:0]  s1_col;
  item_flags_t       s1_flags;
  logic [GEN_W-1:0]  s1_gen;
  logic              s1_move;
  logic              buf_space;
  out_item_t         s1_result;

  assign s1_move    = s1_valid && buf_space;
  assign item_ready = !busy && (!s1_valid || buf_space);
  assign accept     = item_valid && item_ready;

  tcc_cursor_ctrl #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wr_en       (wr_en),
    .wr_entry    (wr_entry),
    .cell_addr   (cell_addr),
    .row         (row),
    .col         (col),
    .flags       (flags),
    .rd_gen      (rd_gen)
  );

  tcc_cell_store #(
    .CELLS (ROWS * COLS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (cell_addr),
    .wr_entry (wr_entry),
    .rd_en    (accept),
    .rd_addr  (cell_addr),
    .rd_entry (rd_entry),
    .busy     (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row   <= row;
      s1_col   <= col;
      s1_flags <= flags;
      s1_gen   <= rd_gen;
    end
  end

  // A cell whose tag differs from its row's generation predates the row's
  // last blanking and reads as a space.
  always_comb begin
    s1_result.cursor_row      = ROW_OUT_W'(s1_row);
    s1_result.cursor_col      = COL_OUT_W'(s1_col);
    s1_result.cursor_position = POS_W'(ADDR_W'(s1_row) * COLS_A + ADDR_W'(s1_col));
    s1_result.set_rejected    = s1_flags.rejected;
    if (!s1_flags.rd_ok) begin
      s1_result.cell_value = '0;
    end else if (rd_entry.gen == s1_gen) begin
      s1_result.cell_value = rd_entry.data;
    end else begin
      s1_result.cell_value = BLANK_CELL;
    end
  end

  tcc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_move),
    .push_item (s1_result),
    .space     (buf_space),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_item  (result)
  );

endmodule

`default_nettype wire

/* tb/sv/tcc_cursor_tracker.sv */
`default_nettype none

module tcc_cursor_tracker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  input  wire logic                       item_ready,
  input  wire tcc_pkg::in_item_t          item,
  input  wire logic                       result_valid,
  input  wire logic                       result_ready,
  input  wire tcc_pkg::out_item_t         result,
  input  wire logic                       cfg_wr_en,
  input  wire logic [tcc_pkg::ATTR_W-1:0] cfg_wr_data,
  output int                              mismatch_count,
  output int                              open_results
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  localparam int ROWS      = ROWS_DEFAULT;
  localparam int COLS      = COLS_DEFAULT;
  localparam int TAB_WIDTH = TAB_WIDTH_DEFAULT;

  logic [ATTR_W-1:0]    text_attr;
  int                   cur_row;
  int                   cur_col;
  int                   top_row;
  logic [CELL_W-1:0]    screen_mem [ROWS*COLS];
  logic                 row_is_blank [ROWS];
  out_item_t            pending_reports [$];

  // Applies one item to the console copy and returns the cursor report it yields.
  function automatic out_item_t console_apply(in_item_t it);
    out_item_t rep;
    int        row;
    int        col;
    int        p;
    int        rin;
    int        cin;
    rep = '0;
    row = cur_row;
    col = cur_col;
    rin = int'(it.row_in);
    cin = int'(it.col_in);
    case (it.kind)
      KIND_PUT: begin
        case (it.char_code)
          CH_BS: if (col > 0) col--;
          CH_TAB: col += TAB_WIDTH - col % TAB_WIDTH;
          CH_CR: col = 0;
          CH_LF: begin
            col = 0;
            row++;
          end
          default: begin
            p = (top_row + row) % ROWS;
            // A blank row becomes real spaces the first time it is written.
            if (row_is_blank[p]) begin
              for (int i = 0; i < COLS; i++) screen_mem[p*COLS + i] = BLANK_CELL;
              row_is_blank[p] = 1'b0;
            end
            screen_mem[p*COLS + col] = {text_attr, it.char_code};
            col++;
          end
        endcase
        if (col >= COLS) begin
          col = 0;
          row++;
        end
        if (row >= ROWS) begin
          row_is_blank[top_row] = 1'b1;
          top_row = (top_row + 1) % ROWS;
          row = ROWS - 1;
        end
        cur_row = row;
        cur_col = col;
      end
      KIND_SET: begin
        if (rin < ROWS && cin < COLS) begin
          cur_row = rin;
          cur_col = cin;
        end else begin
          rep.set_rejected = 1'b1;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < ROWS; i++) row_is_blank[i] = 1'b1;
        top_row = 0;
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
        if (rin < ROWS && cin < COLS) begin
          p = (top_row + rin) % ROWS;
          rep.cell_value = row_is_blank[p] ? BLANK_CELL : screen_mem[p*COLS + cin];
        end else begin
          rep.set_rejected = 1'b1;
        end
      end
    endcase
    rep.cursor_row      = ROW_OUT_W'(cur_row);
    rep.cursor_col      = COL_OUT_W'(cur_col);
    rep.cursor_position = POS_W'(cur_row * COLS + cur_col);
    return rep;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : track
    out_item_t want;
    if (rst) begin
      text_attr = ATTR_RESET;
      cur_row   = 0;
      cur_col   = 0;
      top_row   = 0;
      for (int i = 0; i < ROWS; i++) row_is_blank[i] = 1'b1;
      pending_reports.delete();
    end else begin
      // A result always leaves after its item is accepted, so pop before push.
      if (result_valid && result_ready) begin
        if (pending_reports.size() == 0) begin
          $error("result item arrived with no item outstanding");
          mismatch_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("cursor_row", 32'(want.cursor_row), 32'(result.cursor_row));
          check_field("cursor_col", 32'(want.cursor_col), 32'(result.cursor_col));
          check_field("cursor_position", 32'(want.cursor_position),
                      32'(result.cursor_position));
          check_field("cell_value", 32'(want.cell_value), 32'(result.cell_value));
          check_field("set_rejected", 32'(want.set_rejected), 32'(result.set_rejected));
        end
      end
      if (item_valid && item_ready) pending_reports.push_back(console_apply(item));
      if (cfg_wr_en) text_attr = cfg_wr_data;
    end
    open_results = pending_reports.size();
  end

endmodule

`default_nettype wire

/* tb/sv/tb_text_console_cursor_engine.sv */
`default_nettype none

module tb_text_console_cursor_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  localparam int ROWS       = ROWS_DEFAULT;
  localparam int COLS       = COLS_DEFAULT;
  localparam int MAX_CYCLES = 200000;
  localparam int HOLD_CYCLES = 300;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  in_item_t          item         = '0;
  logic              result_ready = 1'b0;
  logic              cfg_wr_en    = 1'b0;
  logic [ATTR_W-1:0] cfg_wr_data  = '0;
  logic              hold_off_req = 1'b0;
  logic              item_ready;
  logic              result_valid;
  out_item_t         result;

  int mismatch_count;
  int open_results;
  int items_sent;
  int results_seen;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_left;
  bit stall_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_console_cursor_engine u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  tcc_cursor_tracker u_tracker (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .open_results   (open_results)
  );

  // Receiver: random back-pressure, plus one long hold-off once requested.
  always @(posedge clk) begin
    if (result_valid && result_ready) results_seen++;
    if (hold_off_req && !stall_done) begin
      stall_done = 1'b1;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic in_item_t make_item(kind_t k, logic [7:0] ch, logic [5:0] r,
                                         logic [7:0] c);
    in_item_t it;
    it.kind      = k;
    it.char_code = ch;
    it.row_in    = r;
    it.col_in    = c;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       sel;
    it.kind      = KIND_PUT;
    it.char_code = 8'($urandom_range(255));
    it.row_in    = 6'($urandom_range(63));
    it.col_in    = 8'($urandom_range(255));
    sel = int'($urandom_range(99));
    if (sel < 62) begin
      case ($urandom_range(9))
        0: begin
          case ($urandom_range(3))
            0: it.char_code = CH_BS;
            1: it.char_code = CH_TAB;
            2: it.char_code = CH_CR;
            default: it.char_code = CH_LF;
          endcase
        end
        1, 2: ;
        default: it.char_code = 8'($urandom_range(8'h7e, 8'h20));
      endcase
    end else if (sel < 77) begin
      it.kind = KIND_SET;
      // Mostly legal positions, often near the bottom so that scrolling happens.
      if ($urandom_range(4) != 0) begin
        it.row_in = $urandom_range(1) ? 6'($urandom_range(ROWS-1))
                                      : 6'($urandom_range(ROWS-1, ROWS-3));
        it.col_in = 8'($urandom_range(COLS-1));
      end
    end else if (sel < 98) begin
      it.kind = KIND_READ;
      if ($urandom_range(5) != 0) begin
        it.row_in = 6'($urandom_range(ROWS-1));
        it.col_in = 8'($urandom_range(COLS-1));
      end
    end else begin
      it.kind = KIND_CLEAR;
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_ready !== 1'b1);
    items_sent++;
  endtask

  task automatic drain_and_write_attr(logic [ATTR_W-1:0] value);
    item_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset attribute.
    send_item(make_item(KIND_READ, 8'h00, 6'd0, 8'd0));
    send_item(make_item(KIND_PUT, 8'h41, 6'd0, 8'd0));
    send_item(make_item(KIND_PUT, 8'h00, 6'd63, 8'd255));
    send_item(make_item(KIND_PUT, 8'hFF, 6'd0, 8'd0));
    send_item(make_item(KIND_PUT, 8'h80, 6'd0, 8'd0));
    send_item(make_item(KIND_READ, 8'hFF, 6'd0, 8'd0));
    send_item(make_item(KIND_SET, 8'h00, 6'd0, 8'd0));
    send_item(make_item(KIND_PUT, CH_BS, 6'd0, 8'd0));
    send_item(make_item(KIND_PUT, CH_TAB, 6'd0, 8'd0));
    send_item(make_item(KIND_PUT, CH_BS, 6'd0, 8'd0));
    send_item(make_item(KIND_PUT, CH_CR, 6'd0, 8'd0));
    send_item(make_item(KIND_SET, 8'h00, 6'd25, 8'd0));
    send_item(make_item(KIND_SET, 8'h00, 6'd0, 8'd80));
    send_item(make_item(KIND_SET, 8'h00, 6'd63, 8'd255));
    send_item(make_item(KIND_READ, 8'h00, 6'd25, 8'd0));
    send_item(make_item(KIND_READ, 8'h00, 6'd0, 8'd80));
    send_item(make_item(KIND_SET, 8'h00, 6'd3, 8'd77));
    send_item(make_item(KIND_PUT, CH_TAB, 6'd0, 8'd0));
    send_item(make_item(KIND_SET, 8'h00, 6'd24, 8'd79));
    send_item(make_item(KIND_PUT, 8'h5A, 6'd0, 8'd0));
    send_item(make_item(KIND_READ, 8'h00, 6'd23, 8'd79));
    send_item(make_item(KIND_READ, 8'h00, 6'd24, 8'd0));
    send_item(make_item(KIND_PUT, CH_LF, 6'd0, 8'd0));
    send_item(make_item(KIND_CLEAR, 8'h00, 6'd0, 8'd0));
    send_item(make_item(KIND_READ, 8'h00, 6'd0, 8'd1));

    drain_and_write_attr(8'hFF);
    send_idle_pct = 28;
    recv_idle_pct = 46;
    send_random(700);

    drain_and_write_attr(8'h00);
    send_idle_pct = 46;
    recv_idle_pct = 28;
    send_random(700);

    drain_and_write_attr(8'($urandom_range(255)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req <= 1'b1;
    send_random(600);

    item_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (20) @(posedge clk);
    if (open_results != 0) $error("%0d result items never arrived", open_results);
    if (mismatch_count == 0 && open_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
